@@ hdl/rpvg_pkg.sv @@
// ----------------------------------------------------------------------------
// rpvg_pkg: shared types, constants and functions for the polygon generator
// Holds payload structs, trig polynomial constants and the step table.
// ----------------------------------------------------------------------------
package rpvg_pkg;

  localparam int unsigned MaxVertices = 32;
  localparam int unsigned PhaseBits   = 16;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_CENTER_X = 1'b0,
    REG_CENTER_Y = 1'b1
  } reg_idx_e;

  // polynomial coefficients, Q30
  localparam logic [31:0] C1 = 32'd1686629713;
  localparam logic [31:0] C3 = 32'd693598667;
  localparam logic [31:0] C5 = 32'd85569312;
  localparam logic [31:0] C7 = 32'd5026998;
  localparam logic [31:0] C9 = 32'd172272;

  typedef struct packed {
    logic [5:0]  vertex_count;
    logic [15:0] radius;
    logic [15:0] start_phase;
  } req_t;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic [4:0]         vertex_index;
    logic               last_vertex;
  } vtx_t;

  // round(2^pb / n), halves up; elaboration-time style constant arithmetic
  function automatic logic [24:0] step_of(input int unsigned pb, input logic [6:0] n);
    logic [24:0] r;
    r = 25'd0;
    for (int unsigned i = 1; i <= 64; i++) begin
      if (n == 7'(i)) r = 25'(((64'd1 << pb) + 64'(i / 2)) / 64'(i));
    end
    return r;
  endfunction

endpackage

@@ hdl/rpvg_trig.sv @@
// ----------------------------------------------------------------------------
// rpvg_trig: pipelined sine evaluation and coordinate scaling
// Nine register stages: fold, z^2, four Horner steps one per stage,
// final product, radius product, round with center add and saturation.
// ----------------------------------------------------------------------------
module rpvg_trig (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [31:0]        u_i,
  input  logic [15:0]        radius_i,
  input  logic signed [15:0] center_i,
  output logic               vld_o,
  output logic signed [15:0] coord_o
);

  localparam int unsigned NS = 9;

  logic [NS-1:0]       vld_q;
  logic [1:0]          quad_q [NS];
  logic [15:0]         rad_q  [NS];
  logic signed [15:0]  cen_q  [NS];
  logic [30:0] z_q, z2_q, t_q;
  logic [30:0] t3_q, t4_q;
  logic [30:0] z_d;
  logic [31:0] ta_q, tb_q, tc_q, td_q;
  logic [31:0] s_q;
  logic signed [17:0] trig_q;
  logic signed [34:0] prod_q;
  logic signed [15:0] coord_q;
  logic [30:0] z1_q, z2b_q, z3_q, z4_q, z5_q;
  logic [31:0] sd;
  logic signed [36:0] sum;

  always_comb begin
    z_d = {1'b0, u_i[29:0]};
    if (u_i[30]) z_d = 31'h4000_0000 - z_d;
  end

  function automatic logic [31:0] hstep(input logic [31:0] c, input logic [30:0] z2,
                                        input logic [31:0] t);
    logic [63:0] p;
    p = 64'(z2) * 64'(t);
    return c - p[61:30];
  endfunction

  function automatic logic signed [15:0] sat(input logic signed [36:0] v);
    if (v > 37'sd32767) return 16'sh7fff;
    if (v < -37'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction

  // stage valid and side data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q[0] <= u_i[31:30];
      rad_q[0]  <= radius_i;
      cen_q[0]  <= center_i;
      for (int i = 1; i < NS; i++) begin
        quad_q[i] <= quad_q[i-1];
        rad_q[i]  <= rad_q[i-1];
        cen_q[i]  <= cen_q[i-1];
      end
      // s0: fold
      z_q   <= z_d;
      // s1: z^2
      z2_q  <= 31'((64'(z_q) * 64'(z_q)) >> 30);
      z1_q  <= z_q;
      // s2..s5: Horner steps
      ta_q  <= hstep(rpvg_pkg::C7, z2_q, rpvg_pkg::C9);
      t_q   <= z2_q;
      z2b_q <= z1_q;
      tb_q  <= hstep(rpvg_pkg::C5, t_q, ta_q);
      t3_q  <= t_q;
      z3_q  <= z2b_q;
      tc_q  <= hstep(rpvg_pkg::C3, t3_q, tb_q);
      t4_q  <= t3_q;
      z4_q  <= z3_q;
      td_q  <= hstep(rpvg_pkg::C1, t4_q, tc_q);
      z5_q  <= z4_q;
      // s6: final product
      s_q   <= 32'((64'(z5_q) * 64'(td_q)) >> 30);
      // s7: round, clamp, sign, radius product
      prod_q <= 35'(signed'({1'b0, rad_q[6]})) * 35'(trig_q);
      // s8: round and saturate
      coord_q <= sat(sum);
    end
  end

  // z^2 travels with each item through the Horner stages (t_q, t3_q, t4_q)
  // trig value from s_q, combinational into the multiply stage
  always_comb begin
    sd = (s_q + 32'd16384) >> 15;
    if (sd > 32'd32768) sd = 32'd32768;
    trig_q = quad_q[6][1] ? -18'(sd) : 18'(sd);
  end

  assign sum = 37'((37'(prod_q) + 37'sd16384) >>> 15) + 37'(cen_q[7]);

  assign vld_o   = vld_q[NS-1];
  assign coord_o = coord_q;

endmodule

@@ hdl/regular_polygon_vertex_generator.sv @@
// ----------------------------------------------------------------------------
// regular_polygon_vertex_generator: regular polygon vertex stream
// Channel   | Dir | Payload
// req       | in  | rpvg_pkg::req_t (count, radius, start phase)
// vtx       | out | rpvg_pkg::vtx_t (x, y, index, last)
// cfg       | in  | index + 16-bit data (center x, center y)
// A request of n vertices enters the trig pipeline one vertex per cycle while
// the output is not stalled; the next request is taken once all n are issued,
// and a zero-count request does not block the next one. Each vertex passes the
// trig stages and the output register; vertices follow one per cycle unless stalled.
// Output stalls freeze the whole pipeline; nothing is lost or repeated.
// Reset clears centers and all valid bits.
// ----------------------------------------------------------------------------
module regular_polygon_vertex_generator #(
  parameter int unsigned MAX_VERTICES = rpvg_pkg::MaxVertices,
  parameter int unsigned PHASE_BITS   = rpvg_pkg::PhaseBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  rpvg_pkg::req_t req_i,
  output logic           vtx_valid_o,
  input  logic           vtx_ready_i,
  output rpvg_pkg::vtx_t vtx_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [0:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i
);

  localparam int unsigned LAT = 9;

  logic signed [15:0] cx_q, cy_q;
  logic               busy_q;
  logic [6:0]         left_q;
  logic [4:0]         k_q;
  logic [PHASE_BITS-1:0] ph_q, step_q;
  logic [15:0]        rad_q;
  logic [6:0]         n_eff;
  logic               en, iss, vx, vy;
  logic [31:0]        us, uc;
  logic signed [15:0] x, y;
  logic [4:0]         idx_q [LAT];
  logic [LAT-1:0]     lst_q;
  rpvg_pkg::vtx_t     out_q;
  logic               out_v_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
    end else if (cfg_valid_i) begin
      case (rpvg_pkg::reg_idx_e'(cfg_index_i))
        rpvg_pkg::REG_CENTER_X: cx_q <= cfg_data_i;
        rpvg_pkg::REG_CENTER_Y: cy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advances unless the output register is full and stalled
  assign en = !out_v_q || vtx_ready_i;
  assign req_ready_o = en && !busy_q;
  assign iss = busy_q && en;

  always_comb begin
    n_eff = {1'b0, req_i.vertex_count};
    if (n_eff > 7'(MAX_VERTICES)) n_eff = 7'(MAX_VERTICES);
  end

  // phase sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      left_q <= '0;
    end else if (req_valid_i && req_ready_o) begin
      busy_q <= (n_eff != 7'd0);
      left_q <= n_eff;
    end else if (iss) begin
      left_q <= left_q - 7'd1;
      busy_q <= (left_q != 7'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      ph_q   <= PHASE_BITS'(req_i.start_phase);
      step_q <= PHASE_BITS'(rpvg_pkg::step_of(PHASE_BITS, n_eff));
      rad_q  <= req_i.radius;
      k_q    <= '0;
    end else if (iss) begin
      ph_q <= ph_q - step_q;
      k_q  <= k_q + 5'd1;
    end
  end

  assign us = {ph_q, {(32-PHASE_BITS){1'b0}}};
  assign uc = us + 32'h4000_0000;

  rpvg_trig u_x (.clk_i, .rst_ni, .en_i(en), .vld_i(iss), .u_i(uc),
                 .radius_i(rad_q), .center_i(cx_q), .vld_o(vx), .coord_o(x));
  rpvg_trig u_y (.clk_i, .rst_ni, .en_i(en), .vld_i(iss), .u_i(us),
                 .radius_i(rad_q), .center_i(cy_q), .vld_o(vy), .coord_o(y));

  // index and last flag ride alongside
  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q[0] <= k_q;
      lst_q[0] <= (left_q == 7'd1);
      for (int i = 1; i < LAT; i++) begin
        idx_q[i] <= idx_q[i-1];
        lst_q[i] <= lst_q[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= vx;
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= '{vertex_x: x, vertex_y: y, vertex_index: idx_q[LAT-1],
                       last_vertex: lst_q[LAT-1]};
  end

  assign vtx_valid_o = out_v_q;
  assign vtx_o       = out_q;

  a_xy_vld: assert property (@(posedge clk_i) disable iff (!rst_ni) vx == vy)
    else $error("x/y pipelines out of step");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid_o && !vtx_ready_i |=> vtx_valid_o && $stable(vtx_o))
    else $error("stalled vertex changed");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> left_q != 7'd0)
    else $error("sequencer busy with no vertices left");

endmodule

@@ tb/sv/rpvg_vertex_checker.sv @@
// ----------------------------------------------------------------------------
// rpvg_vertex_checker: vertex stream predictor and scoreboard
// Watches the request, vertex and register channels of the polygon generator,
// computes the expected vertices of each accepted request and compares every
// vertex transfer, field by field, against the oldest expected one.
// ----------------------------------------------------------------------------
module rpvg_vertex_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_ready_i,
  input  rpvg_pkg::req_t req_i,
  input  logic           vtx_valid_i,
  input  logic           vtx_ready_i,
  input  rpvg_pkg::vtx_t vtx_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [0:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             vertices_seen_o
);

  logic signed [15:0] ctr_x;
  logic signed [15:0] ctr_y;
  rpvg_pkg::vtx_t     vertex_q[$];

  // Q15 sine of a 32-bit turn fraction, odd polynomial over a quarter turn
  function automatic longint sine_q15(input logic [31:0] u);
    logic [1:0]  quad;
    logic [63:0] z, z2, t, s;
    quad = u[31:30];
    z    = {34'd0, u[29:0]};
    if (quad[0]) z = 64'h4000_0000 - z;
    z2 = (z * z) >> 30;
    t  = 64'(rpvg_pkg::C9);
    t  = 64'(rpvg_pkg::C7) - ((z2 * t) >> 30);
    t  = 64'(rpvg_pkg::C5) - ((z2 * t) >> 30);
    t  = 64'(rpvg_pkg::C3) - ((z2 * t) >> 30);
    t  = 64'(rpvg_pkg::C1) - ((z2 * t) >> 30);
    s  = (z * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  // center + radius * trig, rounded half up to Q12.4, saturated
  function automatic logic signed [15:0] place(input logic signed [15:0] c,
                                               input logic [15:0] r,
                                               input longint trig);
    longint v;
    v = longint'(c) + ((longint'(r) * trig + 64'sd16384) >>> 15);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // expand one request into its vertex list
  task automatic predict_polygon(input rpvg_pkg::req_t r);
    int unsigned n, stride;
    logic [15:0] ang;
    logic [31:0] u;
    rpvg_pkg::vtx_t v;
    n = r.vertex_count;
    if (n == 0) return;
    if (n > rpvg_pkg::MaxVertices) n = rpvg_pkg::MaxVertices;
    stride = (32'd65536 + n / 2) / n;
    for (int unsigned k = 0; k < n; k++) begin
      ang            = 16'(r.start_phase - k * stride);
      u              = {ang, 16'd0};
      v.vertex_x     = place(ctr_x, r.radius, sine_q15(u + 32'h4000_0000));
      v.vertex_y     = place(ctr_y, r.radius, sine_q15(u));
      v.vertex_index = 5'(k);
      v.last_vertex  = (k + 1 == n);
      vertex_q       = {vertex_q, v};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rpvg_pkg::vtx_t want;
    if (!rst_ni) begin
      ctr_x           = '0;
      ctr_y           = '0;
      vertex_q.delete();
      fail_count_o    = 0;
      vertices_seen_o = 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (rpvg_pkg::reg_idx_e'(cfg_index_i))
          rpvg_pkg::REG_CENTER_X: ctr_x = cfg_data_i;
          rpvg_pkg::REG_CENTER_Y: ctr_y = cfg_data_i;
          default: ;
        endcase
      end
      // vertex transfers
      if (vtx_valid_i && vtx_ready_i) begin
        vertices_seen_o++;
        if (vertex_q.size() == 0) begin
          $error("unexpected vertex transfer: %p", vtx_i);
          fail_count_o++;
        end else begin
          want = vertex_q.pop_front();
          if (vtx_i.vertex_x !== want.vertex_x) begin
            $error("vertex_x: expected %0d, got %0d", want.vertex_x, vtx_i.vertex_x);
            fail_count_o++;
          end
          if (vtx_i.vertex_y !== want.vertex_y) begin
            $error("vertex_y: expected %0d, got %0d", want.vertex_y, vtx_i.vertex_y);
            fail_count_o++;
          end
          if (vtx_i.vertex_index !== want.vertex_index) begin
            $error("vertex_index: expected %0d, got %0d", want.vertex_index,
                   vtx_i.vertex_index);
            fail_count_o++;
          end
          if (vtx_i.last_vertex !== want.last_vertex) begin
            $error("last_vertex: expected %0b, got %0b", want.last_vertex,
                   vtx_i.last_vertex);
            fail_count_o++;
          end
        end
      end
      // request transfers
      if (req_valid_i && req_ready_i) predict_polygon(req_i);
    end
    pending_o = vertex_q.size();
  end

endmodule

@@ tb/sv/tb_regular_polygon_vertex_generator.sv @@
// ----------------------------------------------------------------------------
// tb_regular_polygon_vertex_generator: polygon generator testbench
// Drives directed and random polygon requests under several center settings,
// with random gaps on the request side and random stalls on the vertex side.
// The checker beside the block predicts and compares every vertex.
// ----------------------------------------------------------------------------
module tb_regular_polygon_vertex_generator;

  localparam int CycleLimit = 3_000_000;
  localparam int DrainWait  = 40;
  localparam int RandomReqs = 480;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           req_valid = 1'b0;
  logic           req_ready;
  rpvg_pkg::req_t req = '0;
  logic           vtx_valid;
  logic           vtx_ready = 1'b0;
  rpvg_pkg::vtx_t vtx;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [0:0]     cfg_index = '0;
  logic [15:0]    cfg_data = '0;
  int             fail_count, pending, vertices_seen;
  int             cycles = 0;
  int             req_sent = 0;
  int             stall_left = 0;
  bit             steady = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  regular_polygon_vertex_generator dut (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .vtx_valid_o(vtx_valid), .vtx_ready_i(vtx_ready), .vtx_o(vtx),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  rpvg_vertex_checker u_checker (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_ready_i(req_ready), .req_i(req),
    .vtx_valid_i(vtx_valid), .vtx_ready_i(vtx_ready), .vtx_i(vtx),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .vertices_seen_o(vertices_seen)
  );

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("regular_polygon_vertex_generator: mismatch");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 70) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // vertex-side back pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        vtx_ready  <= 1'b0;
      end else begin
        stall_left <= gap_len();
        vtx_ready  <= 1'b1;
      end
    end
  end

  task automatic send_polygon(input logic [5:0] n, input logic [15:0] r,
                              input logic [15:0] ph);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    req_valid        <= 1'b1;
    req.vertex_count <= n;
    req.radius       <= r;
    req.start_phase  <= ph;
    do @(posedge clk_i); while (!req_ready);
    req_sent++;
  endtask

  // let all expected vertices arrive, plus a wait longer than the pipeline depth
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // valid stays high; the caller lowers it after the last write
  task automatic write_reg(input rpvg_pkg::reg_idx_e idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic set_center(input logic [15:0] x, input logic [15:0] y);
    drain();
    write_reg(rpvg_pkg::REG_CENTER_X, x);
    write_reg(rpvg_pkg::REG_CENTER_Y, y);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [5:0] pick_count();
    int p;
    p = $urandom_range(0, 99);
    if (p < 4) return 6'd0;
    if (p < 9) return 6'($urandom_range(33, 63));
    if (p < 20) return 6'($urandom_range(13, 32));
    return 6'($urandom_range(1, 12));
  endfunction

  task automatic random_polygons(input int cnt);
    logic [15:0] r;
    for (int i = 0; i < cnt; i++) begin
      r = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
      send_polygon(pick_count(), r, 16'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: count edges, radius and phase extremes at the reset center
    send_polygon(6'd1, 16'd160, 16'd0);
    send_polygon(6'd2, 16'hFFFF, 16'hFFFF);
    send_polygon(6'd3, 16'd0, 16'h8000);
    send_polygon(6'd0, 16'd500, 16'h1234);
    send_polygon(6'd4, 16'd4096, 16'h4000);
    send_polygon(6'd32, 16'hFFFF, 16'h0000);
    send_polygon(6'd33, 16'd1000, 16'hC000);
    send_polygon(6'd63, 16'd7, 16'h0001);
    send_polygon(6'd7, 16'h8000, 16'h2AAA);

    // directed: saturation at the corner centers
    set_center(16'h7FFF, 16'h8000);
    send_polygon(6'd8, 16'hFFFF, 16'h1000);
    send_polygon(6'd5, 16'd16, 16'hFFFF);
    send_polygon(6'd0, 16'd16, 16'd0);
    set_center(16'h8000, 16'h7FFF);
    send_polygon(6'd6, 16'hFFFF, 16'h0000);
    send_polygon(6'd31, 16'h4000, 16'h5555);

    // random phases under several centers, one with no idling
    set_center(16'd0, 16'd0);
    random_polygons(RandomReqs / 4);
    set_center(16'($urandom), 16'($urandom));
    steady = 1'b1;
    random_polygons(RandomReqs / 4);
    steady = 1'b0;
    set_center(16'h7FFF, 16'h7FFF);
    random_polygons(RandomReqs / 4);
    set_center(16'h8000, 16'h8000);
    random_polygons(RandomReqs / 4);

    drain();
    $display("Covered %0d polygon requests, %0d vertices checked, over seven center settings.",
             req_sent, vertices_seen);
    if (fail_count == 0) begin
      $display("regular_polygon_vertex_generator: match");
    end else begin
      $display("regular_polygon_vertex_generator: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rpvg_pkg.sv
hdl/rpvg_trig.sv
hdl/regular_polygon_vertex_generator.sv
tb/sv/rpvg_vertex_checker.sv
tb/sv/tb_regular_polygon_vertex_generator.sv
